// ===== src/pidm_pkg.sv =====
// ----------------------------------------------------------------------------
// pidm_pkg
// Shared widths, register indexes and payload types for the PID position
// move controller and its serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pidm_pkg;

   localparam int POSITION_BITS  = 24;
   localparam int ERR_BITS       = POSITION_BITS + 1;
   localparam int DIFF_BITS      = ERR_BITS + 1;
   localparam int GAIN_BITS      = 16;
   localparam int PROD_BITS      = DIFF_BITS + GAIN_BITS;
   localparam int ACC_BITS       = PROD_BITS + 2;
   localparam int INTEG_BITS     = 8;
   localparam int INTEG_SUM_BITS = ERR_BITS + 1;
   localparam int TOL_BITS       = 16;
   localparam int CMP_BITS       = (ERR_BITS > TOL_BITS + 1) ? ERR_BITS : TOL_BITS + 1;
   localparam int PERIOD_BITS    = 8;
   localparam int POWER_BITS     = 16;
   localparam int FRAC_BITS      = 8;
   localparam int DIV_COUNT_BITS = $clog2(PROD_BITS);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;

   localparam int INTEGRAL_LIMIT = 100;

   localparam logic signed [POWER_BITS-1:0] POWER_MAX = 16'sh7fff;
   localparam logic signed [POWER_BITS-1:0] POWER_MIN = 16'sh8000;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SET_POINT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REVERSE_DRIVE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DONE_TOLERANCE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_P         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_I         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_D         = 3'd5;

   typedef struct packed {
      logic                            command;
      logic signed [POSITION_BITS-1:0] position;
      logic [PERIOD_BITS-1:0]          elapsed_periods;
   } req_type;

   typedef struct packed {
      logic signed [POWER_BITS-1:0] drive_power;
      logic                         move_done;
   } rsp_type;

   typedef struct packed {
      logic                        start;
      logic signed [PROD_BITS-1:0] dividend;
      logic [PERIOD_BITS-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [PROD_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== src/pidm_div.sv =====
// ----------------------------------------------------------------------------
// pidm_div
// Serial signed divide by a non-zero unsigned period count, one quotient bit
// per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pidm_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pidm_pkg::div_req_type div_req,
   output pidm_pkg::div_rsp_type     div_rsp
);
   import pidm_pkg::*;

   localparam logic [DIV_COUNT_BITS-1:0] LAST_COUNT = DIV_COUNT_BITS'(PROD_BITS - 1);

   logic                      busy_ff;
   logic                      fix_ff;
   logic                      done_ff;
   logic                      neg_ff;
   logic [DIV_COUNT_BITS-1:0] count_ff;
   logic [PROD_BITS-1:0]      quo_ff;
   logic [PERIOD_BITS-1:0]    rem_ff;
   logic [PERIOD_BITS-1:0]    divisor_ff;

   logic [PERIOD_BITS:0]      trial;
   logic                      fits;
   logic [PERIOD_BITS:0]      trial_sub;
   logic [PROD_BITS-1:0]      dividend_mag;

   assign trial        = {rem_ff, quo_ff[PROD_BITS-1]};
   assign fits         = trial >= {1'b0, divisor_ff};
   assign trial_sub    = trial - {1'b0, divisor_ff};
   assign dividend_mag = div_req.dividend[PROD_BITS-1] ? (~div_req.dividend + 1'b1)
                                                       : div_req.dividend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fix_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff    <= 1'b1;
            count_ff   <= '0;
            quo_ff     <= dividend_mag;
            neg_ff     <= div_req.dividend[PROD_BITS-1];
            rem_ff     <= '0;
            divisor_ff <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff   <= fits ? trial_sub[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            quo_ff   <= {quo_ff[PROD_BITS-2:0], fits};
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_COUNT) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            quo_ff  <= neg_ff ? (~quo_ff + 1'b1) : quo_ff;
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== src/pid_position_move_controller.sv =====
// ----------------------------------------------------------------------------
// pid_position_move_controller
// PID position move controller with integral clamp, built around one shared
// multiplier and a serial divider under a small sequencer.
//
// Usage: configure set point, reverse flag, tolerance and Q8.8 gains through
// the csr_ write port while no request is in flight. A request with command
// start opens a move and answers at once with power 0, done 0. A request with
// command step runs one control update; when no move is active it answers
// power 0, done 1. Every request gives exactly one response.
// Sequence: start and idle step requests place their response in the output
// register at the accepting edge. An active step runs a prepare step, three
// passes through the shared 26x16 multiplier, then the bit-serial divide of
// the derivative term (one bit per cycle over the 42-bit product), a sum and
// a finish step.
// Throughput: one request at a time; req_stall is high while a step is in
// progress and while a finished response is held by rsp_stall.
// Reset: synchronous; clears configuration, state, response valid, integral,
// last error and the move.
`default_nettype none

module pid_position_move_controller (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire pidm_pkg::req_type                     req_data,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      pidm_pkg::rsp_type                     rsp_data,
   input  wire logic                                  csr_write,
   input  wire logic [pidm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pidm_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import pidm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_MUL_P,
      S_MUL_I,
      S_MUL_D,
      S_DIV,
      S_WAIT,
      S_FINISH
   } state_type;

   localparam logic signed [INTEG_SUM_BITS-1:0] LIMIT_HI = INTEG_SUM_BITS'(INTEGRAL_LIMIT);
   localparam logic signed [INTEG_SUM_BITS-1:0] LIMIT_LO = INTEG_SUM_BITS'(-INTEGRAL_LIMIT);

   // configuration
   logic signed [POSITION_BITS-1:0] set_point_ff;
   logic                            reverse_drive_ff;
   logic [TOL_BITS-1:0]             done_tolerance_ff;
   logic signed [GAIN_BITS-1:0]     gain_p_ff;
   logic signed [GAIN_BITS-1:0]     gain_i_ff;
   logic signed [GAIN_BITS-1:0]     gain_d_ff;

   // move state
   state_type                       state_ff;
   logic signed [ERR_BITS-1:0]      last_error_ff;
   logic signed [INTEG_BITS-1:0]    integral_sum_ff;
   logic                            move_active_ff;

   // working registers
   logic signed [ERR_BITS-1:0]      err_ff;
   logic signed [DIFF_BITS-1:0]     diff_ff;
   logic signed [INTEG_BITS-1:0]    integ_ff;
   logic [PERIOD_BITS-1:0]          periods_ff;
   logic                            overshoot_ff;
   logic                            done_ff;
   logic signed [PROD_BITS-1:0]     prod_ff;
   logic signed [ACC_BITS-1:0]      acc_ff;
   logic                            rsp_valid_ff;
   rsp_type                         rsp_data_ff;

   logic                            out_free;
   logic                            req_take;
   logic signed [ERR_BITS-1:0]      sp_ext;
   logic signed [ERR_BITS-1:0]      pos_ext;
   logic signed [ERR_BITS-1:0]      req_error;
   logic [ERR_BITS-1:0]             sp_mag;
   logic [ERR_BITS-1:0]             pos_mag;
   logic signed [INTEG_SUM_BITS-1:0] integ_raw;
   logic                            sign_flip;
   logic signed [INTEG_BITS-1:0]    integ_next;
   logic signed [CMP_BITS-1:0]      err_cmp;
   logic signed [CMP_BITS-1:0]      tol_cmp;
   logic signed [DIFF_BITS-1:0]     mul_a;
   logic signed [GAIN_BITS-1:0]     mul_b;
   logic signed [PROD_BITS-1:0]     mul_p;
   logic signed [ACC_BITS-1:0]      acc_shift;
   logic signed [POWER_BITS-1:0]    power_sat;
   logic signed [POWER_BITS-1:0]    power_ovr;
   logic signed [POWER_BITS-1:0]    power_out;
   div_req_type                     div_req;
   div_rsp_type                     div_rsp;

   function automatic logic signed [POWER_BITS-1:0] neg_sat(
      input logic signed [POWER_BITS-1:0] value
   );
      logic signed [POWER_BITS-1:0] res;
      res = (value == POWER_MIN) ? POWER_MAX : -value;
      return res;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;

   assign sp_ext    = ERR_BITS'(set_point_ff);
   assign pos_ext   = ERR_BITS'(req_data.position);
   assign req_error = sp_ext - pos_ext;
   assign sp_mag    = sp_ext[ERR_BITS-1] ? -sp_ext : sp_ext;
   assign pos_mag   = pos_ext[ERR_BITS-1] ? -pos_ext : pos_ext;

   // integral with sign-change reset and clamp
   assign integ_raw = INTEG_SUM_BITS'(err_ff) + INTEG_SUM_BITS'(integral_sum_ff);
   assign sign_flip = ((err_ff[ERR_BITS-1] || (err_ff == '0)) &&
                       !last_error_ff[ERR_BITS-1] && (last_error_ff != '0)) ||
                      (!err_ff[ERR_BITS-1] && last_error_ff[ERR_BITS-1]);

   always_comb begin
      if (sign_flip) begin
         integ_next = '0;
      end else if (integ_raw > LIMIT_HI) begin
         integ_next = INTEG_BITS'(LIMIT_HI);
      end else if (integ_raw < LIMIT_LO) begin
         integ_next = INTEG_BITS'(LIMIT_LO);
      end else begin
         integ_next = INTEG_BITS'(integ_raw);
      end
   end

   assign err_cmp = CMP_BITS'(err_ff);
   assign tol_cmp = CMP_BITS'($signed({1'b0, done_tolerance_ff}));

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MUL_P: begin
            mul_a = DIFF_BITS'(err_ff);
            mul_b = gain_p_ff;
         end
         S_MUL_I: begin
            mul_a = DIFF_BITS'(integ_ff);
            mul_b = gain_i_ff;
         end
         S_MUL_D: begin
            mul_a = diff_ff;
            mul_b = gain_d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign div_req.start    = (state_ff == S_DIV);
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = periods_ff;

   pidm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // power: floor shift, saturate, overshoot and reverse negation
   assign acc_shift = acc_ff >>> FRAC_BITS;

   always_comb begin
      if ((&acc_shift[ACC_BITS-1:POWER_BITS-1]) || !(|acc_shift[ACC_BITS-1:POWER_BITS-1])) begin
         power_sat = acc_shift[POWER_BITS-1:0];
      end else if (acc_shift[ACC_BITS-1]) begin
         power_sat = POWER_MIN;
      end else begin
         power_sat = POWER_MAX;
      end
   end

   assign power_ovr = overshoot_ff ? neg_sat(power_sat) : power_sat;
   assign power_out = reverse_drive_ff ? neg_sat(power_ovr) : power_ovr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff      <= '0;
         reverse_drive_ff  <= 1'b0;
         done_tolerance_ff <= '0;
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_SET_POINT:      set_point_ff      <= csr_data[POSITION_BITS-1:0];
            REG_REVERSE_DRIVE:  reverse_drive_ff  <= csr_data[0];
            REG_DONE_TOLERANCE: done_tolerance_ff <= csr_data[TOL_BITS-1:0];
            REG_GAIN_P:         gain_p_ff         <= csr_data[GAIN_BITS-1:0];
            REG_GAIN_I:         gain_i_ff         <= csr_data[GAIN_BITS-1:0];
            REG_GAIN_D:         gain_d_ff         <= csr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         last_error_ff   <= '0;
         integral_sum_ff <= '0;
         move_active_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  if (req_data.command == CMD_START) begin
                     last_error_ff         <= req_error;
                     integral_sum_ff       <= '0;
                     move_active_ff        <= 1'b1;
                     rsp_valid_ff          <= 1'b1;
                     rsp_data_ff.drive_power <= '0;
                     rsp_data_ff.move_done <= 1'b0;
                  end else if (!move_active_ff) begin
                     rsp_valid_ff          <= 1'b1;
                     rsp_data_ff.drive_power <= '0;
                     rsp_data_ff.move_done <= 1'b1;
                  end else begin
                     err_ff       <= req_error;
                     overshoot_ff <= pos_mag > sp_mag;
                     periods_ff   <= (req_data.elapsed_periods == '0) ? PERIOD_BITS'(1)
                                                                      : req_data.elapsed_periods;
                     state_ff     <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               integ_ff <= integ_next;
               diff_ff  <= DIFF_BITS'(err_ff) - DIFF_BITS'(last_error_ff);
               done_ff  <= err_cmp <= tol_cmp;
               state_ff <= S_MUL_P;
            end
            S_MUL_P: begin
               prod_ff  <= mul_p;
               state_ff <= S_MUL_I;
            end
            S_MUL_I: begin
               acc_ff   <= ACC_BITS'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= S_MUL_D;
            end
            S_MUL_D: begin
               acc_ff   <= acc_ff + ACC_BITS'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_rsp.done) begin
                  acc_ff   <= acc_ff + ACC_BITS'($signed(div_rsp.quotient));
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.drive_power <= power_out;
                  rsp_data_ff.move_done   <= done_ff;
                  integral_sum_ff         <= integ_ff;
                  last_error_ff           <= err_ff;
                  if (done_ff) begin
                     move_active_ff <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
